/* design/cms_pkg.sv */
// Shared constants and types for the complex magnitude sorter.
package cms_pkg;

	localparam int MAX_ELEMENTS_DEF = 32;
	localparam int VALUE_WIDTH_DEF  = 32;
	localparam int FIELD_W          = 32;
	localparam int IDX_W            = 5;
	localparam int QUEUE_DEPTH      = 4;
	localparam int QPTR_W           = 2;
	localparam int QLVL_W           = 3;

	typedef struct packed {
		logic              empty;
		logic [QLVL_W-1:0] level;
	} q_stat_t;

endpackage

/* design/cms_front.sv */
// Front end: takes requests, numbers them and forms the squared-magnitude key.
module cms_front #(
	parameter int MAX_ELEMENTS = cms_pkg::MAX_ELEMENTS_DEF,
	parameter int VALUE_WIDTH  = cms_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [cms_pkg::FIELD_W-1:0]  re_part,
	input  logic signed [cms_pkg::FIELD_W-1:0]  im_part,
	input  logic                                final_item,
	input  cms_pkg::q_stat_t                    q_stat,
	output logic                                busy,
	output logic                                push,
	output logic signed [VALUE_WIDTH-1:0]       push_re,
	output logic signed [VALUE_WIDTH-1:0]       push_im,
	output logic [2*VALUE_WIDTH-1:0]            push_key,
	output logic [cms_pkg::IDX_W-1:0]           push_idx,
	output logic                                push_last
);

	localparam int CNT_W = $clog2(MAX_ELEMENTS);
	localparam int KEY_W = 2 * VALUE_WIDTH;

	logic                          accept;
	logic                          last_in;
	logic [CNT_W-1:0]              cnt_q;
	logic [cms_pkg::QLVL_W:0]      pending;

	logic                          v_s1;
	logic signed [VALUE_WIDTH-1:0] re_s1;
	logic signed [VALUE_WIDTH-1:0] im_s1;
	logic [cms_pkg::IDX_W-1:0]     idx_s1;
	logic                          last_s1;

	logic                          v_s2;
	logic signed [VALUE_WIDTH-1:0] re_s2;
	logic signed [VALUE_WIDTH-1:0] im_s2;
	logic signed [KEY_W-1:0]       rsq_s2;
	logic signed [KEY_W-1:0]       isq_s2;
	logic [cms_pkg::IDX_W-1:0]     idx_s2;
	logic                          last_s2;

	// Hold off requests while the queue could not take every item in flight
	assign pending = (cms_pkg::QLVL_W+1)'(q_stat.level)
		+ (cms_pkg::QLVL_W+1)'(v_s1) + (cms_pkg::QLVL_W+1)'(v_s2);
	assign busy    = pending >= (cms_pkg::QLVL_W+1)'(cms_pkg::QUEUE_DEPTH);
	assign accept  = start && !busy;

	// End the set on the marked item or when the store is full
	assign last_in = final_item || (cnt_q == CNT_W'(MAX_ELEMENTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			if (accept) begin
				cnt_q <= last_in ? '0 : cnt_q + CNT_W'(1);
			end
		end
	end

	// Capture the request, keeping only the low value bits
	always_ff @(posedge clk) begin
		if (accept) begin
			re_s1   <= re_part[VALUE_WIDTH-1:0];
			im_s1   <= im_part[VALUE_WIDTH-1:0];
			idx_s1  <= cms_pkg::IDX_W'(cnt_q);
			last_s1 <= last_in;
		end
	end

	// Square both parts
	always_ff @(posedge clk) begin
		if (v_s1) begin
			re_s2   <= re_s1;
			im_s2   <= im_s1;
			rsq_s2  <= KEY_W'(re_s1) * KEY_W'(re_s1);
			isq_s2  <= KEY_W'(im_s1) * KEY_W'(im_s1);
			idx_s2  <= idx_s1;
			last_s2 <= last_s1;
		end
	end

	// Sum the squares and hand the item to the queue
	assign push      = v_s2;
	assign push_re   = re_s2;
	assign push_im   = im_s2;
	assign push_key  = KEY_W'($unsigned(rsq_s2)) + KEY_W'($unsigned(isq_s2));
	assign push_idx  = idx_s2;
	assign push_last = last_s2;

endmodule

/* design/cms_queue.sv */
// Short first-in first-out queue between the front and back ends.
module cms_queue #(
	parameter int WIDTH = 4 * cms_pkg::VALUE_WIDTH_DEF + cms_pkg::IDX_W + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output cms_pkg::q_stat_t q_stat
);

	logic [WIDTH-1:0]              data_q [cms_pkg::QUEUE_DEPTH];
	logic [cms_pkg::QPTR_W-1:0]    wr_q;
	logic [cms_pkg::QPTR_W-1:0]    rd_q;
	logic [cms_pkg::QLVL_W-1:0]    level_q;

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + cms_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + cms_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + cms_pkg::QLVL_W'(1);
				2'b01:   level_q <= level_q - cms_pkg::QLVL_W'(1);
				default: level_q <= level_q;
			endcase
		end
	end

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_q] <= push_data;
		end
	end

	assign pop_data     = data_q[rd_q];
	assign q_stat.empty = (level_q == '0);
	assign q_stat.level = level_q;

endmodule

/* design/cms_back.sv */
// Back end: ordered insertion into a cell chain, then shift-out of the sorted set.
module cms_back #(
	parameter int MAX_ELEMENTS = cms_pkg::MAX_ELEMENTS_DEF,
	parameter int VALUE_WIDTH  = cms_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cms_pkg::q_stat_t                     q_stat,
	input  logic signed [VALUE_WIDTH-1:0]        in_re,
	input  logic signed [VALUE_WIDTH-1:0]        in_im,
	input  logic [2*VALUE_WIDTH-1:0]             in_key,
	input  logic [cms_pkg::IDX_W-1:0]            in_idx,
	input  logic                                 in_last,
	output logic                                 pop,
	output logic                                 strobe,
	output logic signed [cms_pkg::FIELD_W-1:0]   sorted_re,
	output logic signed [cms_pkg::FIELD_W-1:0]   sorted_im,
	output logic [cms_pkg::IDX_W-1:0]            source_index,
	output logic                                 end_of_run
);

	localparam int KEY_W = 2 * VALUE_WIDTH;

	logic                          emit_q;
	logic                          vld_q [MAX_ELEMENTS];
	logic signed [VALUE_WIDTH-1:0] re_q  [MAX_ELEMENTS];
	logic signed [VALUE_WIDTH-1:0] im_q  [MAX_ELEMENTS];
	logic [KEY_W-1:0]              key_q [MAX_ELEMENTS];
	logic [cms_pkg::IDX_W-1:0]     idx_q [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0]       gt;

	logic                          out_vld_q;
	logic signed [VALUE_WIDTH-1:0] out_re_q;
	logic signed [VALUE_WIDTH-1:0] out_im_q;
	logic [cms_pkg::IDX_W-1:0]     out_idx_q;
	logic                          out_end_q;

	// Take a request from the queue only while not draining a set
	assign pop = !emit_q && !q_stat.empty;

	// Each cell compares; strict greater keeps equal keys in load order
	always_comb begin
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			gt[i] = !vld_q[i] || (in_key > key_q[i]);
		end
	end

	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		logic take_new;
		logic take_prev;
		logic next_vld;
		logic signed [VALUE_WIDTH-1:0] next_re;
		logic signed [VALUE_WIDTH-1:0] next_im;
		logic [KEY_W-1:0]              next_key;
		logic [cms_pkg::IDX_W-1:0]     next_idx;

		// Insert here at the first cell that the new key beats, shift below it
		if (i == 0) begin : g_head
			assign take_new  = gt[i];
			assign take_prev = 1'b0;
		end else begin : g_body
			assign take_new  = gt[i] && !gt[i-1];
			assign take_prev = gt[i] && gt[i-1];
		end

		// Neighbour towards the tail feeds this cell during shift-out
		if (i == MAX_ELEMENTS - 1) begin : g_tail
			assign next_vld = 1'b0;
			assign next_re  = re_q[i];
			assign next_im  = im_q[i];
			assign next_key = key_q[i];
			assign next_idx = idx_q[i];
		end else begin : g_link
			assign next_vld = vld_q[i+1];
			assign next_re  = re_q[i+1];
			assign next_im  = im_q[i+1];
			assign next_key = key_q[i+1];
			assign next_idx = idx_q[i+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (emit_q) begin
				vld_q[i] <= next_vld;
			end else if (pop && gt[i]) begin
				vld_q[i] <= take_new ? 1'b1 : vld_q[(i == 0) ? 0 : i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (emit_q) begin
				re_q[i]  <= next_re;
				im_q[i]  <= next_im;
				key_q[i] <= next_key;
				idx_q[i] <= next_idx;
			end else if (pop && take_new) begin
				re_q[i]  <= in_re;
				im_q[i]  <= in_im;
				key_q[i] <= in_key;
				idx_q[i] <= in_idx;
			end else if (pop && take_prev) begin
				re_q[i]  <= re_q[(i == 0) ? 0 : i-1];
				im_q[i]  <= im_q[(i == 0) ? 0 : i-1];
				key_q[i] <= key_q[(i == 0) ? 0 : i-1];
				idx_q[i] <= idx_q[(i == 0) ? 0 : i-1];
			end
		end
	end

	// Drain after the last item of a set is inserted, stop when the chain empties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= emit_q && vld_q[0];
			if (emit_q && !vld_q[1]) begin
				emit_q <= 1'b0;
			end else if (pop && in_last) begin
				emit_q <= 1'b1;
			end
		end
	end

	// Register the head cell as the result
	always_ff @(posedge clk) begin
		if (emit_q) begin
			out_re_q  <= re_q[0];
			out_im_q  <= im_q[0];
			out_idx_q <= idx_q[0];
			out_end_q <= !vld_q[1];
		end
	end

	assign strobe       = out_vld_q;
	assign sorted_re    = cms_pkg::FIELD_W'(out_re_q);
	assign sorted_im    = cms_pkg::FIELD_W'(out_im_q);
	assign source_index = out_idx_q;
	assign end_of_run   = out_end_q;

endmodule

/* design/complex_magnitude_sorter.sv */
// Top level of the complex magnitude sorter: front end, queue and sorting back end.
//
//  channel   handshake          fields
//  request   start / busy       re_part, im_part, final_item
//  result    strobe             sorted_re, sorted_im, source_index, end_of_run
//
// A request is taken in any cycle with start high and busy low; busy is high
// while the queue and the two front stages together hold four items.
// Items pass the capture and squaring registers and the queue to the chain.
// After the last item of a set is inserted, n results follow one per cycle,
// each via the output registers once emit_q is set; the receiver cannot stall them.
// While a set drains, requests are still taken until the queue fills.
// Reset clears the element count, the queue and the chain valid bits.
module complex_magnitude_sorter #(
	parameter int MAX_ELEMENTS = cms_pkg::MAX_ELEMENTS_DEF,
	parameter int VALUE_WIDTH  = cms_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [cms_pkg::FIELD_W-1:0]  re_part,
	input  logic signed [cms_pkg::FIELD_W-1:0]  im_part,
	input  logic                                final_item,
	output logic                                strobe,
	output logic signed [cms_pkg::FIELD_W-1:0]  sorted_re,
	output logic signed [cms_pkg::FIELD_W-1:0]  sorted_im,
	output logic [cms_pkg::IDX_W-1:0]           source_index,
	output logic                                end_of_run
);

	localparam int KEY_W = 2 * VALUE_WIDTH;
	localparam int ENT_W = 2 * VALUE_WIDTH + KEY_W + cms_pkg::IDX_W + 1;

	cms_pkg::q_stat_t              q_stat;
	logic                          push;
	logic signed [VALUE_WIDTH-1:0] push_re;
	logic signed [VALUE_WIDTH-1:0] push_im;
	logic [KEY_W-1:0]              push_key;
	logic [cms_pkg::IDX_W-1:0]     push_idx;
	logic                          push_last;
	logic                          pop;
	logic [ENT_W-1:0]              push_data;
	logic [ENT_W-1:0]              pop_data;
	logic signed [VALUE_WIDTH-1:0] pop_re;
	logic signed [VALUE_WIDTH-1:0] pop_im;
	logic [KEY_W-1:0]              pop_key;
	logic [cms_pkg::IDX_W-1:0]     pop_idx;
	logic                          pop_last;

	cms_front #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.VALUE_WIDTH  (VALUE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.re_part    (re_part),
		.im_part    (im_part),
		.final_item (final_item),
		.q_stat     (q_stat),
		.busy       (busy),
		.push       (push),
		.push_re    (push_re),
		.push_im    (push_im),
		.push_key   (push_key),
		.push_idx   (push_idx),
		.push_last  (push_last)
	);

	// Pack and unpack queue entries
	assign push_data = {push_re, push_im, push_key, push_idx, push_last};
	assign {pop_re, pop_im, pop_key, pop_idx, pop_last} = pop_data;

	cms_queue #(
		.WIDTH (ENT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	cms_back #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.VALUE_WIDTH  (VALUE_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.in_re        (pop_re),
		.in_im        (pop_im),
		.in_key       (pop_key),
		.in_idx       (pop_idx),
		.in_last      (pop_last),
		.pop          (pop),
		.strobe       (strobe),
		.sorted_re    (sorted_re),
		.sorted_im    (sorted_im),
		.source_index (source_index),
		.end_of_run   (end_of_run)
	);

`ifndef SYNTHESIS
	// A full queue must hold off new requests
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.level == cms_pkg::QLVL_W'(cms_pkg::QUEUE_DEPTH)) |-> busy)
		else $error("queue full without busy");

	// Never push into a full queue unless it pops in the same cycle
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && (q_stat.level == cms_pkg::QLVL_W'(cms_pkg::QUEUE_DEPTH))) |-> pop)
		else $error("queue overflow");

	// The end of a set is followed by a gap before the next set
	a_end_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && end_of_run) |=> !strobe)
		else $error("result directly after end of set");

	// An empty queue is never popped
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue underflow");
`endif

endmodule

/* verif/complex_magnitude_sorter_tb.sv */
// Self-checking testbench for the complex magnitude sorter: directed table, then random sets.
`timescale 1ns / 1ps

module complex_magnitude_sorter_tb;

	localparam int MAX_ELEMENTS = cms_pkg::MAX_ELEMENTS_DEF;
	localparam int RANDOM_ITEMS = 110;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE       = 40;
	localparam int PLAN_ROWS    = 19;

	typedef logic signed [cms_pkg::FIELD_W-1:0] part_t;

	// one stored element of the set being loaded
	typedef struct {
		part_t                     re;
		part_t                     im;
		bit [63:0]                 key;
		logic [cms_pkg::IDX_W-1:0] idx;
	} element_t;

	// one sorted result as it should leave the block
	typedef struct {
		part_t                     re;
		part_t                     im;
		logic [cms_pkg::IDX_W-1:0] idx;
		logic                      last;
	} result_t;

	// directed row: request fields, plus a typed-in result where one is obvious
	typedef struct {
		part_t   re;
		part_t   im;
		logic    fin;
		bit      typed;
		result_t want;
	} plan_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	part_t                     re_part;
	part_t                     im_part;
	logic                      final_item;
	logic                      strobe;
	part_t                     sorted_re;
	part_t                     sorted_im;
	logic [cms_pkg::IDX_W-1:0] source_index;
	logic                      end_of_run;

	element_t loaded_set[$];
	result_t  awaited_sorted[$];
	int       fail_count   = 0;
	int       items_sent   = 0;
	int       sets_closed  = 0;
	int       full_sets    = 0;
	int       results_seen = 0;
	int       cycle_count  = 0;
	bit       gaps_on      = 1'b1;

	complex_magnitude_sorter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.re_part      (re_part),
		.im_part      (im_part),
		.final_item   (final_item),
		.strobe       (strobe),
		.sorted_re    (sorted_re),
		.sorted_im    (sorted_im),
		.source_index (source_index),
		.end_of_run   (end_of_run)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// squared magnitude from the raw integers, exact in 64 unsigned bits
	function automatic bit [63:0] squared_magnitude(input part_t re, input part_t im);
		longint    sr;
		longint    si;
		bit [63:0] ar;
		bit [63:0] ai;
		sr = re;
		si = im;
		ar = (sr < 0) ? 64'(-sr) : 64'(sr);
		ai = (si < 0) ? 64'(-si) : 64'(si);
		return ar * ar + ai * ai;
	endfunction

	// hold the element; on the closing request, rank the set largest first, ties in load order
	task automatic rank_request(input part_t re, input part_t im, input logic fin,
			output result_t batch[$]);
		element_t held;
		element_t ranked[$];
		result_t  r;
		int       pos;
		batch = {};
		held.re  = re;
		held.im  = im;
		held.key = squared_magnitude(re, im);
		held.idx = cms_pkg::IDX_W'(loaded_set.size());
		loaded_set.push_back(held);
		if (!fin && loaded_set.size() < MAX_ELEMENTS)
			return;
		foreach (loaded_set[i]) begin
			pos = ranked.size();
			foreach (ranked[j]) begin
				if (ranked[j].key < loaded_set[i].key) begin
					pos = j;
					break;
				end
			end
			ranked.insert(pos, loaded_set[i]);
		end
		foreach (ranked[i]) begin
			r.re   = ranked[i].re;
			r.im   = ranked[i].im;
			r.idx  = ranked[i].idx;
			r.last = (i == ranked.size() - 1);
			batch.push_back(r);
		end
		if (loaded_set.size() == MAX_ELEMENTS)
			full_sets++;
		sets_closed++;
		loaded_set = {};
	endtask

	// issue one request, with an occasional idle burst ahead of it; return at acceptance
	task automatic send_item(input part_t re, input part_t im, input logic fin,
			input bit typed, input result_t typed_res);
		result_t batch[$];
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		start      <= 1'b1;
		re_part    <= re;
		im_part    <= im;
		final_item <= fin;
		do @(posedge clk); while (busy);
		rank_request(re, im, fin, batch);
		if (typed)
			batch = '{typed_res};
		foreach (batch[i])
			awaited_sorted.push_back(batch[i]);
		items_sent++;
	endtask

	// random part value: full range, small, extremes or whole Q16.16 numbers
	function automatic part_t pick_part();
		case ($urandom_range(0, 4))
			0, 1: return part_t'($urandom);
			2: return part_t'($urandom_range(0, 511)) - 256;
			3: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return -1;
					default: return 0;
				endcase
			end
			default: return part_t'($urandom_range(0, 65535) << 16);
		endcase
	endfunction

	// directed rows: single-element sets have their result typed in, the rest are predicted
	plan_row_t plan [PLAN_ROWS] = '{
		'{32'sh0000_0000, 32'sh0000_0000, 1'b1, 1'b1,
			'{32'sh0000_0000, 32'sh0000_0000, 5'd0, 1'b1}},
		'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b1,
			'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5'd0, 1'b1}},
		'{32'sh8000_0000, 32'sh8000_0000, 1'b1, 1'b1,
			'{32'sh8000_0000, 32'sh8000_0000, 5'd0, 1'b1}},
		'{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b1,
			'{32'sh8000_0000, 32'sh7FFF_FFFF, 5'd0, 1'b1}},
		'{32'shFFFF_FFFF, 32'sh0000_0001, 1'b1, 1'b1,
			'{32'shFFFF_FFFF, 32'sh0000_0001, 5'd0, 1'b1}},
		'{32'sh0001_0000, 32'sh0000_0000, 1'b1, 1'b1,
			'{32'sh0001_0000, 32'sh0000_0000, 5'd0, 1'b1}},
		// equal keys must keep load order
		'{32'sh0000_0003, 32'sh0000_0004, 1'b0, 1'b0, '{0, 0, 0, 0}},
		'{-32'sh0000_0004, 32'sh0000_0003, 1'b0, 1'b0, '{0, 0, 0, 0}},
		'{32'sh0000_0000, -32'sh0000_0005, 1'b0, 1'b0, '{0, 0, 0, 0}},
		'{32'sh0000_0001, 32'sh0000_0001, 1'b0, 1'b0, '{0, 0, 0, 0}},
		'{32'sh8000_0000, 32'sh0000_0000, 1'b0, 1'b0, '{0, 0, 0, 0}},
		'{32'sh0000_0005, 32'sh0000_0000, 1'b1, 1'b0, '{0, 0, 0, 0}},
		// rising keys closed by a zero: the rising ones come out reversed, the zero last
		'{32'sh0000_0001, 32'sh0000_0000, 1'b0, 1'b0, '{0, 0, 0, 0}},
		'{32'sh0000_0002, 32'sh0000_0000, 1'b0, 1'b0, '{0, 0, 0, 0}},
		'{32'sh0000_0003, 32'sh0000_0000, 1'b0, 1'b0, '{0, 0, 0, 0}},
		'{32'sh0000_0000, 32'sh0000_0000, 1'b1, 1'b0, '{0, 0, 0, 0}},
		// alternating bit patterns
		'{32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, 1'b0, '{0, 0, 0, 0}},
		'{32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, 1'b0, '{0, 0, 0, 0}},
		'{32'shFFFF_FFFF, 32'sh0000_0001, 1'b1, 1'b0, '{0, 0, 0, 0}}
	};

	// compare each strobed result with the oldest one awaited
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && strobe) begin
			results_seen++;
			if (awaited_sorted.size() == 0) begin
				$error("unexpected result: re=%0d im=%0d index=%0d end=%0b",
					sorted_re, sorted_im, source_index, end_of_run);
				fail_count++;
			end else begin
				want = awaited_sorted.pop_front();
				if (sorted_re !== want.re) begin
					$error("sorted_re: expected %0d, got %0d", want.re, sorted_re);
					fail_count++;
				end
				if (sorted_im !== want.im) begin
					$error("sorted_im: expected %0d, got %0d", want.im, sorted_im);
					fail_count++;
				end
				if (source_index !== want.idx) begin
					$error("source_index: expected %0d, got %0d", want.idx, source_index);
					fail_count++;
				end
				if (end_of_run !== want.last) begin
					$error("end_of_run: expected %0b, got %0b", want.last, end_of_run);
					fail_count++;
				end
			end
		end
	end

	// abandon the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("complex_magnitude_sorter: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		result_t none;
		part_t   re;
		part_t   im;
		part_t   rot;
		int      set_size;
		bit      close_by_fill;
		none = '{0, 0, 0, 0};
		arst_n     <= 1'b0;
		start      <= 1'b0;
		re_part    <= '0;
		im_part    <= '0;
		final_item <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (plan[i])
			send_item(plan[i].re, plan[i].im, plan[i].fin, plan[i].typed, plan[i].want);

		// random sets; the first fills the store with no final mark
		for (int s = 0; items_sent < PLAN_ROWS + RANDOM_ITEMS; s++) begin
			close_by_fill = 1'b0;
			if (s == 0) begin
				set_size = MAX_ELEMENTS;
				close_by_fill = 1'b1;
			end else if ($urandom_range(0, 7) == 0) begin
				set_size = MAX_ELEMENTS;
				close_by_fill = $urandom_range(0, 1);
			end else begin
				set_size = $urandom_range(1, 6);
			end
			// drop idle gaps for the closing stretch
			if (items_sent >= PLAN_ROWS + (RANDOM_ITEMS * 3) / 4)
				gaps_on = 1'b0;
			for (int k = 0; k < set_size; k++) begin
				// now and then repeat the previous magnitude to exercise tie order
				if (k > 0 && $urandom_range(0, 3) == 0) begin
					if ($urandom_range(0, 1)) begin
						rot = re;
						re  = -im;
						im  = rot;
					end else begin
						re = -re;
					end
				end else begin
					re = pick_part();
					im = pick_part();
				end
				send_item(re, im, (k == set_size - 1) && !close_by_fill, 1'b0, none);
			end
		end
		start <= 1'b0;

		// drain, then watch for stray results
		while (awaited_sorted.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d requests in %0d sets, %0d of them filling the store.",
			items_sent, sets_closed, full_sets);
		$display("Checked %0d sorted results field by field.", results_seen);
		if (fail_count == 0) begin
			$display("complex_magnitude_sorter: match");
		end else begin
			$display("complex_magnitude_sorter: mismatch");
		end
		$finish;
	end

endmodule

/* files.f */
design/cms_pkg.sv
design/cms_front.sv
design/cms_queue.sv
design/cms_back.sv
design/complex_magnitude_sorter.sv
verif/complex_magnitude_sorter_tb.sv
